### rtl/wpsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpsc_pkg
// Shared types, constants and the arctangent table of the steering controller.
// ----------------------------------------------------------------------------
package wpsc_pkg;

   localparam int MAX_WAYPOINTS = 64;
   localparam int WP_IDX_W      = $clog2(MAX_WAYPOINTS);

   localparam int SLOT_W   = 6;
   localparam int POS_W    = 24;
   localparam int HEAD_W   = 16;
   localparam int GAIN_W   = 16;
   localparam int SPEED_W  = 16;
   localparam int TURN_W   = 22;
   localparam int CSR_IDX_W = 3;

   localparam int DX_W     = POS_W + 1;
   localparam int MUL_W    = DX_W + 1;
   localparam int PROD_W   = 2 * MUL_W;
   localparam int D2_W     = 2 * DX_W;
   localparam int CX_W     = DX_W + 19;
   localparam int CZ_W     = 28;
   localparam int ERR_W    = 18;
   localparam int CORDIC_STEPS = 25;
   localparam int STEP_W   = $clog2(CORDIC_STEPS);

   localparam int PI_Q13      = 25736;
   localparam int HALF_PI_Q24 = 26353589;

   localparam logic [CSR_IDX_W-1:0] CSR_STEER_GAIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_GAIN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_LIMIT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REACH       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PATH_LAST   = 3'd4;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_POSE = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIFF, ST_SQX, ST_SQY, ST_SUM, ST_CMP,
      ST_ITER, ST_ERR, ST_TURN, ST_SPD, ST_OUT
   } state_type;

   typedef enum logic [1:0] {PASS_GOAL, PASS_STEP, PASS_DRIVE} pass_type;

   typedef struct packed {
      logic start;
   } iter_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } iter_sts_type;

   function automatic logic [23:0] atan_entry(input logic [STEP_W-1:0] i);
      logic [23:0] v;
      case (i)
         5'd0:  v = 24'd13176795;
         5'd1:  v = 24'd7778716;
         5'd2:  v = 24'd4110060;
         5'd3:  v = 24'd2086331;
         5'd4:  v = 24'd1047214;
         5'd5:  v = 24'd524117;
         5'd6:  v = 24'd262123;
         5'd7:  v = 24'd131069;
         5'd8:  v = 24'd65536;
         5'd9:  v = 24'd32768;
         5'd10: v = 24'd16384;
         5'd11: v = 24'd8192;
         5'd12: v = 24'd4096;
         5'd13: v = 24'd2048;
         5'd14: v = 24'd1024;
         5'd15: v = 24'd512;
         5'd16: v = 24'd256;
         5'd17: v = 24'd128;
         5'd18: v = 24'd64;
         5'd19: v = 24'd32;
         5'd20: v = 24'd16;
         5'd21: v = 24'd8;
         5'd22: v = 24'd4;
         5'd23: v = 24'd2;
         5'd24: v = 24'd1;
         default: v = 24'd0;
      endcase
      return v;
   endfunction

endpackage

### rtl/wpsc_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpsc_req_if
// Request channel: waypoint loads and pose updates.
// ----------------------------------------------------------------------------
interface wpsc_req_if;
   import wpsc_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     action;
   logic [SLOT_W-1:0]        waypoint_slot;
   logic signed [POS_W-1:0]  point_x;
   logic signed [POS_W-1:0]  point_y;
   logic signed [HEAD_W-1:0] pose_heading;

   modport source (output valid, action, waypoint_slot, point_x, point_y, pose_heading,
                   input ready);
   modport sink   (input valid, action, waypoint_slot, point_x, point_y, pose_heading,
                   output ready);
endinterface

### rtl/wpsc_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpsc_rsp_if
// Response channel: drive commands.
// ----------------------------------------------------------------------------
interface wpsc_rsp_if;
   import wpsc_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [SPEED_W-1:0]       forward_speed;
   logic signed [TURN_W-1:0] turn_rate;
   logic                     at_goal;
   logic [SLOT_W-1:0]        target_slot;

   modport source (output valid, forward_speed, turn_rate, at_goal, target_slot,
                   input ready);
   modport sink   (input valid, forward_speed, turn_rate, at_goal, target_slot,
                   output ready);
endinterface

### rtl/wpsc_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpsc_store
// Waypoint memory with per-entry valid bits; unwritten entries read as zero.
// ----------------------------------------------------------------------------
module wpsc_store (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            wr_en,
   input  logic [wpsc_pkg::WP_IDX_W-1:0]   wr_addr,
   input  logic [2*wpsc_pkg::POS_W-1:0]    wr_data,
   input  logic                            rd_en,
   input  logic [wpsc_pkg::WP_IDX_W-1:0]   rd_addr,
   output logic [2*wpsc_pkg::POS_W-1:0]    rd_data
);
   import wpsc_pkg::*;

   logic [2*POS_W-1:0]     mem [MAX_WAYPOINTS];
   logic [MAX_WAYPOINTS-1:0] valid_ff;
   logic [2*POS_W-1:0]     data_ff;
   logic                   hit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            hit_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = hit_ff ? data_ff : '0;
endmodule

### rtl/wpsc_iter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpsc_iter
// Shared iteration unit: one CORDIC vectoring step and one square-root digit
// per cycle, giving bearing and distance.
// ----------------------------------------------------------------------------
module wpsc_iter (
   input  logic                                clock,
   input  logic                                reset,
   input  wpsc_pkg::iter_ctl_type              ctl,
   input  logic signed [wpsc_pkg::DX_W-1:0]    dx,
   input  logic signed [wpsc_pkg::DX_W-1:0]    dy,
   input  logic [wpsc_pkg::D2_W-1:0]           d2,
   output wpsc_pkg::iter_sts_type              sts,
   output logic [wpsc_pkg::DX_W-1:0]           distance,
   output logic signed [wpsc_pkg::HEAD_W-1:0]  bearing
);
   import wpsc_pkg::*;

   logic signed [CX_W-1:0] x_ff, y_ff, x_in, y_in;
   logic signed [CZ_W-1:0] z_ff, z_in;
   logic [D2_W-1:0]        n_ff, n_in, res_ff, res_in;
   logic [STEP_W-1:0]      step_ff;
   logic                   busy_ff, done_ff, zero_ff;

   logic signed [CX_W-1:0] x0, y0, xs, ys;
   logic signed [CZ_W-1:0] ang;
   logic [5:0]             sh;
   logic [D2_W-1:0]        bitv, trial;
   logic [CZ_W-1:0]        zmag;
   logic [HEAD_W-1:0]      zr;

   always_comb begin
      x0 = CX_W'(dx) <<< 16;
      y0 = CX_W'(dy) <<< 16;
      xs = x_ff >>> step_ff;
      ys = y_ff >>> step_ff;
      ang = signed'(CZ_W'(atan_entry(step_ff)));
      sh = 6'(2 * (CORDIC_STEPS - 1)) - {step_ff, 1'b0};
      bitv = D2_W'(1) << sh;
      trial = res_ff + bitv;
      // rotate toward the x axis
      if (y_ff > 0) begin
         x_in = x_ff + ys;
         y_in = y_ff - xs;
         z_in = z_ff + ang;
      end else begin
         x_in = x_ff - ys;
         y_in = y_ff + xs;
         z_in = z_ff - ang;
      end
      // one root digit
      if (n_ff >= trial) begin
         n_in   = n_ff - trial;
         res_in = (res_ff >> 1) + bitv;
      end else begin
         n_in   = n_ff;
         res_in = res_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         n_ff    <= d2;
         res_ff  <= '0;
         zero_ff <= (dx == '0) && (dy == '0);
         if (x0 < 0) begin
            if (y0 >= 0) begin
               x_ff <= y0;
               y_ff <= -x0;
               z_ff <= CZ_W'(HALF_PI_Q24);
            end else begin
               x_ff <= -y0;
               y_ff <= x0;
               z_ff <= -CZ_W'(HALF_PI_Q24);
            end
         end else begin
            x_ff <= x0;
            y_ff <= y0;
            z_ff <= '0;
         end
      end else if (busy_ff) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
         n_ff   <= n_in;
         res_ff <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               step_ff <= step_ff + 1'b1;
            end
         end
      end
   end

   // round half away from zero to Q3.13
   always_comb begin
      zmag = z_ff[CZ_W-1] ? CZ_W'(-z_ff) : CZ_W'(z_ff);
      zr   = HEAD_W'((zmag + CZ_W'(1024)) >> 11);
      if (zero_ff) begin
         bearing = '0;
      end else begin
         bearing = z_ff[CZ_W-1] ? -signed'(zr) : signed'(zr);
      end
   end

   assign distance = DX_W'(res_ff);
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
endmodule

### rtl/waypoint_p_steering_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_p_steering_controller
// Proportional go-to-waypoint drive controller with waypoint store.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries load transfers (action 0: waypoint into waypoint_slot) and
//   pose transfers (action 1: robot x, y, heading). Each pose gives exactly one
//   transfer on rsp_ch; loads give none.
//   csr_we/csr_index/csr_wdata write the gains, speed limit, reach radius and
//   path start; write them only while the block is idle. Writing the path
//   start also restarts the path and clears the goal latch.
// Sequence:
//   A pose with the goal already latched goes straight to the output step;
//   one that hits waypoint 0 stops after the goal check. A full drive pose
//   runs distance checks against waypoint 0, then the target (skipped when
//   the target is slot 0), then the drive target, through the single 26x26
//   multiplier, then the shared CORDIC/root unit, then error, turn, speed and output steps.
//   req_ch.ready is high only while idle, from the cycle after the output step.
// Reset clears the waypoint valid bits (store reads zero), restores default
//   registers, target slot 0 and the goal latch.
// A stalled rsp_ch holds its result in the output register; the block still
//   takes the next request and waits at the output step until it frees up.
// ----------------------------------------------------------------------------
module waypoint_p_steering_controller (
   input  logic                              clock,
   input  logic                              reset,
   wpsc_req_if.sink                          req_ch,
   wpsc_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [wpsc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [wpsc_pkg::GAIN_W-1:0]       csr_wdata
);
   import wpsc_pkg::*;

   state_type state_ff, state_in;
   pass_type  pass_ff, pass_in;

   // configuration
   logic [GAIN_W-1:0]   steer_gain_ff, speed_gain_ff, speed_limit_ff, reach_ff;
   logic [WP_IDX_W-1:0] target_ff, target_in;
   logic                goal_ff, goal_in;

   // pose and working registers
   logic signed [POS_W-1:0]  px_ff, py_ff;
   logic signed [HEAD_W-1:0] hd_ff;
   logic signed [DX_W-1:0]   dx_ff, dy_ff;
   logic [D2_W-1:0]          acc_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ERR_W-1:0]  err_ff;
   logic signed [TURN_W-1:0] turn_ff;
   logic                     out_goal_ff, out_goal_in;

   // response register
   logic                     rsp_valid_ff;
   logic [SPEED_W-1:0]       rsp_speed_ff;
   logic signed [TURN_W-1:0] rsp_turn_ff;
   logic                     rsp_goal_ff;
   logic [SLOT_W-1:0]        rsp_slot_ff;

   // store
   logic                  st_wr_en, st_rd_en;
   logic [WP_IDX_W-1:0]   st_wr_addr, st_rd_addr;
   logic [2*POS_W-1:0]    st_rd_data;
   logic signed [POS_W-1:0] wp_x, wp_y;

   // shared multiplier
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_p;

   iter_ctl_type        it_ctl;
   iter_sts_type        it_sts;
   logic [DX_W-1:0]     it_dist;
   logic signed [HEAD_W-1:0] it_bear;

   logic req_fire, rsp_free, near;
   logic signed [ERR_W-1:0] err_raw, err_wrap;
   logic [PROD_W-1:0]       tmag, tr;
   logic [PROD_W-1:0]       spd_raw;
   logic [SPEED_W-1:0]      spd_sat;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);

   wpsc_store u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data ({req_ch.point_x, req_ch.point_y}),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   assign wp_x = st_rd_data[2*POS_W-1:POS_W];
   assign wp_y = st_rd_data[POS_W-1:0];

   // drop loads to slots beyond the store
   assign st_wr_en   = req_fire && (req_ch.action == ACT_LOAD)
                       && (32'(req_ch.waypoint_slot) < 32'(MAX_WAYPOINTS));
   assign st_wr_addr = WP_IDX_W'(req_ch.waypoint_slot);

   wpsc_iter u_iter (
      .clock    (clock),
      .reset    (reset),
      .ctl      (it_ctl),
      .dx       (dx_ff),
      .dy       (dy_ff),
      .d2       (acc_ff),
      .sts      (it_sts),
      .distance (it_dist),
      .bearing  (it_bear)
   );

   // multiplier operand select
   always_comb begin
      case (state_ff)
         ST_SQX:  begin mul_a = MUL_W'(dx_ff); mul_b = MUL_W'(dx_ff); end
         ST_SQY:  begin mul_a = MUL_W'(dy_ff); mul_b = MUL_W'(dy_ff); end
         ST_SUM:  begin
            mul_a = signed'(MUL_W'(reach_ff));
            mul_b = signed'(MUL_W'(reach_ff));
         end
         ST_TURN: begin mul_a = signed'(MUL_W'(steer_gain_ff)); mul_b = MUL_W'(err_ff); end
         ST_SPD:  begin
            mul_a = signed'(MUL_W'(speed_gain_ff));
            mul_b = signed'(MUL_W'(it_dist));
         end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // heading error, wrapped once into +-pi
   always_comb begin
      err_raw = ERR_W'(it_bear) - ERR_W'(hd_ff);
      if (err_raw < -ERR_W'(PI_Q13)) begin
         err_wrap = err_raw + ERR_W'(2 * PI_Q13);
      end else if (err_raw > ERR_W'(PI_Q13)) begin
         err_wrap = err_raw - ERR_W'(2 * PI_Q13);
      end else begin
         err_wrap = err_raw;
      end
   end

   // turn: round steer*err / 8192 half away from zero
   always_comb begin
      tmag = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
      tr   = (tmag + PROD_W'(4096)) >> 13;
   end

   // speed: round gain*dist / 4096, saturate at limit
   always_comb begin
      spd_raw = (PROD_W'(prod_ff) + PROD_W'(2048)) >> 12;
      spd_sat = (spd_raw > PROD_W'(speed_limit_ff)) ? speed_limit_ff : SPEED_W'(spd_raw);
   end

   assign near = acc_ff < D2_W'(prod_ff);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      pass_in     = pass_ff;
      target_in   = target_ff;
      goal_in     = goal_ff;
      out_goal_in = out_goal_ff;
      st_rd_en    = 1'b0;
      st_rd_addr  = '0;
      it_ctl.start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_ch.action == ACT_POSE)) begin
               if (goal_ff) begin
                  out_goal_in = 1'b1;
                  state_in    = ST_OUT;
               end else begin
                  out_goal_in = 1'b0;
                  pass_in     = PASS_GOAL;
                  st_rd_en    = 1'b1;
                  st_rd_addr  = '0;
                  state_in    = ST_DIFF;
               end
            end
         end
         ST_DIFF: state_in = ST_SQX;
         ST_SQX:  state_in = ST_SQY;
         ST_SQY:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_CMP;
         ST_CMP: begin
            case (pass_ff)
               PASS_GOAL: begin
                  if (near) begin
                     goal_in     = 1'b1;
                     out_goal_in = 1'b1;
                     state_in    = ST_OUT;
                  end else begin
                     pass_in    = (target_ff != '0) ? PASS_STEP : PASS_DRIVE;
                     st_rd_en   = 1'b1;
                     st_rd_addr = target_ff;
                     state_in   = ST_DIFF;
                  end
               end
               PASS_STEP: begin
                  // advance toward slot 0 on arrival
                  if (near) begin
                     target_in = target_ff - 1'b1;
                  end
                  pass_in    = PASS_DRIVE;
                  st_rd_en   = 1'b1;
                  st_rd_addr = target_in;
                  state_in   = ST_DIFF;
               end
               default: begin
                  it_ctl.start = 1'b1;
                  state_in     = ST_ITER;
               end
            endcase
         end
         ST_ITER: begin
            if (it_sts.done) begin
               state_in = ST_ERR;
            end
         end
         ST_ERR:  state_in = ST_TURN;
         ST_TURN: state_in = ST_SPD;
         ST_SPD:  state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         pass_ff        <= PASS_GOAL;
         target_ff      <= '0;
         goal_ff        <= 1'b0;
         out_goal_ff    <= 1'b0;
         steer_gain_ff  <= GAIN_W'(7373);
         speed_gain_ff  <= GAIN_W'(7373);
         speed_limit_ff <= GAIN_W'(2458);
         reach_ff       <= GAIN_W'(819);
      end else begin
         state_ff    <= state_in;
         pass_ff     <= pass_in;
         out_goal_ff <= out_goal_in;
         if (csr_we && (csr_index == CSR_PATH_LAST)) begin
            // restart path, clamp into the store
            if (32'(csr_wdata[SLOT_W-1:0]) >= 32'(MAX_WAYPOINTS)) begin
               target_ff <= WP_IDX_W'(MAX_WAYPOINTS - 1);
            end else begin
               target_ff <= WP_IDX_W'(csr_wdata[SLOT_W-1:0]);
            end
            goal_ff <= 1'b0;
         end else begin
            target_ff <= target_in;
            goal_ff   <= goal_in;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_STEER_GAIN:  steer_gain_ff  <= csr_wdata;
               CSR_SPEED_GAIN:  speed_gain_ff  <= csr_wdata;
               CSR_SPEED_LIMIT: speed_limit_ff <= csr_wdata;
               CSR_REACH:       reach_ff       <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         px_ff <= req_ch.point_x;
         py_ff <= req_ch.point_y;
         hd_ff <= req_ch.pose_heading;
      end
      case (state_ff)
         ST_DIFF: begin
            dx_ff <= DX_W'(wp_x) - DX_W'(px_ff);
            dy_ff <= DX_W'(wp_y) - DX_W'(py_ff);
         end
         ST_SQX:  prod_ff <= mul_p;
         ST_SQY: begin
            acc_ff  <= D2_W'(prod_ff);
            prod_ff <= mul_p;
         end
         ST_SUM: begin
            acc_ff  <= acc_ff + D2_W'(prod_ff);
            prod_ff <= mul_p;
         end
         ST_ERR:  err_ff <= err_wrap;
         ST_TURN: prod_ff <= mul_p;
         ST_SPD: begin
            turn_ff <= prod_ff[PROD_W-1] ? TURN_W'(-tr) : TURN_W'(tr);
            prod_ff <= mul_p;
         end
         default: ;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_OUT) && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_OUT) && rsp_free) begin
         rsp_goal_ff  <= out_goal_ff;
         rsp_slot_ff  <= SLOT_W'(target_ff);
         rsp_speed_ff <= out_goal_ff ? '0 : spd_sat;
         rsp_turn_ff  <= out_goal_ff ? '0 : turn_ff;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.forward_speed = rsp_speed_ff;
   assign rsp_ch.turn_rate     = rsp_turn_ff;
   assign rsp_ch.at_goal       = rsp_goal_ff;
   assign rsp_ch.target_slot   = rsp_slot_ff;

   // checks
   a_goal_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.at_goal |->
         (rsp_ch.forward_speed == '0) && (rsp_ch.turn_rate == '0))
      else $error("goal result carries nonzero commands");

   a_speed_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.forward_speed <= speed_limit_ff)
      else $error("forward speed above limit");

   a_iter_done: assert property (@(posedge clock) disable iff (reset)
      it_sts.done |-> (state_ff == ST_ITER))
      else $error("iteration unit finished outside its wait step");

   a_iter_start: assert property (@(posedge clock) disable iff (reset)
      it_ctl.start |-> !it_sts.busy && (pass_ff == PASS_DRIVE))
      else $error("iteration unit restarted while busy");
endmodule
